@@ hw/rtl/timing_wheel_server_dispatcher_core_macros.svh @@
// ----------------------------------------------------------------------------
// timing_wheel_server_dispatcher_core_macros
// Assertion macros for the timing wheel dispatcher.
// ----------------------------------------------------------------------------
`ifndef TIMING_WHEEL_SERVER_DISPATCHER_CORE_MACROS_SVH
`define TIMING_WHEEL_SERVER_DISPATCHER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define TW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define TW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/twsd_pkg.sv @@
// ----------------------------------------------------------------------------
// twsd_pkg
// Shared types and codes of the timing wheel server dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none
package twsd_pkg;
	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_ENQUEUE = 2'd1;
	localparam logic [1:0] REQ_SERVICE = 2'd2;

	localparam logic [1:0] RES_START_ACK = 2'd0;
	localparam logic [1:0] RES_ENQ_ACK   = 2'd1;
	localparam logic [1:0] RES_DONE      = 2'd2;
	localparam logic [1:0] RES_EMPTY     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_POP,
		ST_PLACE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [2:0] done_server;
		logic [2:0] done_kind;
		logic       server_freed;
		logic [2:0] dispatched_kind;
		logic       error_flag;
		logic [31:0] processed_count;
		logic       last_result;
	} result_t;
endpackage
`default_nettype wire

@@ hw/rtl/twsd_ram.sv @@
// ----------------------------------------------------------------------------
// twsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module twsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/timing_wheel_server_dispatcher_core.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_server_dispatcher_core
// Timing wheel of busy servers with a FIFO of waiting queries.
// ----------------------------------------------------------------------------
// An enqueue request, or a service of an empty slot, gives its one item in
// the cycle after it is accepted; a start request gives its ack after the
// PLACE and EMIT states. A service request gives one completion item per
// entry in the slot; each completion passes READ (entry read), POP (unlink
// and FIFO pop) and EMIT, with PLACE between when the freed server takes a
// waiting query that is placed again, as the registered-read entry and FIFO
// memories are walked one entry at a time. Result stalls hold EMIT.
// The block accepts no new item until the last result of a request has been
// taken. The output register lets results wait for the downstream side.
`default_nettype none
module timing_wheel_server_dispatcher_core #(
	parameter int SLOTS      = 16,
	parameter int SERVERS    = 8,
	parameter int WAIT_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_type[1:0], server_id[4:2], proc_time[12:5], query_kind[15:13],
	// slot_number[19:16], zero fill [23:20]
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_kind[1:0], done_server[4:2], done_kind[7:5], server_freed[8],
	// dispatched_kind[11:9], error_flag[12], processed_count[44:13], zero fill
	output logic [47:0]      m_tdata,
	output logic             m_tlast
);
	import twsd_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
	localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW = $clog2(WAIT_DEPTH + 1);
	localparam int ENT_W = 1 + EW + 3 + 3;   // has_next, next, server, kind
	localparam int WQ_W  = 8 + 3;            // time, kind

	// request fields
	logic [1:0] in_req;
	logic [2:0] in_srv;
	logic [7:0] in_time;
	logic [2:0] in_kind;
	logic [3:0] in_slot;
	assign in_req  = s_tdata[1:0];
	assign in_srv  = s_tdata[4:2];
	assign in_time = s_tdata[12:5];
	assign in_kind = s_tdata[15:13];
	assign in_slot = s_tdata[19:16];

	state_t state_q, state_d;

	logic [SLOTS-1:0]   slot_valid_q;
	logic [EW-1:0]      slot_heads_q [SLOTS];
	logic [SERVERS-1:0] free_map_q;
	logic [WW-1:0]      wait_rd_q;
	logic [CW-1:0]      wait_cnt_q;
	logic [SW-1:0]      cur_slot_q;
	logic [31:0]        total_q;

	logic [2:0] drn_srv_q, drn_kind_q, disp_kind_q;
	logic       freed_q;
	logic [7:0] pl_time_q;

	result_t res_q;
	logic    res_valid_q;

	// memories
	logic             ent_we;
	logic [EW-1:0]    ent_waddr, ent_raddr;
	logic [ENT_W-1:0] ent_wdata, ent_rdata;
	logic             wq_we;
	logic [WW-1:0]    wq_waddr;
	logic [WQ_W-1:0]  wq_wdata, wq_rdata;

	twsd_ram #(.WIDTH(ENT_W), .DEPTH(SERVERS)) u_ent (
		.clk(clk), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
		.rd_addr(ent_raddr), .rd_data(ent_rdata)
	);
	twsd_ram #(.WIDTH(WQ_W), .DEPTH(WAIT_DEPTH)) u_wq (
		.clk(clk), .wr_en(wq_we), .wr_addr(wq_waddr), .wr_data(wq_wdata),
		.rd_addr(wait_rd_q), .rd_data(wq_rdata)
	);

	// lowest free entry
	logic [EW-1:0] free_idx;
	logic          free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SERVERS - 1; i >= 0; i--) begin
			if (free_map_q[i]) begin
				free_idx = EW'(i);
				free_any = 1'b1;
			end
		end
	end

	logic [SW-1:0] cur_now;
	logic [SW-1:0] pl_slot;
	logic [SW-1:0] in_slot_m;
	logic [SW+8:0] slot_sum;
	assign in_slot_m = SW'(32'(in_slot) % SLOTS);
	always_comb begin
		slot_sum = (SW+9)'(cur_slot_q) + (SW+9)'(pl_time_q);
		pl_slot  = SW'(slot_sum % (SW+9)'(SLOTS));
	end
	assign cur_now = cur_slot_q;

	logic accept;
	assign accept  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !res_valid_q;
	logic res_free;
	assign res_free = !res_valid_q || m_tready;

	logic [EW-1:0] head_e;
	assign head_e = slot_heads_q[cur_now];

	logic start_mode_q;   // PLACE serves a start request

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_req == REQ_SERVICE &&
				    slot_valid_q[in_slot_m]) begin
					state_d = ST_READ;
				end else if (accept && in_req == REQ_START) begin
					state_d = ST_PLACE;
				end
			end
			ST_READ:  state_d = ST_POP;
			ST_POP:   state_d = (wait_cnt_q != '0) ? ST_PLACE : ST_EMIT;
			ST_PLACE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_free) begin
					state_d = start_mode_q ? ST_IDLE :
					          slot_valid_q[cur_now] ? ST_READ : ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		ent_raddr = head_e;
		ent_we    = (state_q == ST_PLACE) && free_any;
		ent_waddr = free_idx;
		ent_wdata = {slot_valid_q[pl_slot], slot_heads_q[pl_slot], drn_srv_q,
		             disp_kind_q};
		wq_we     = accept && in_req == REQ_ENQUEUE &&
		            wait_cnt_q < CW'(WAIT_DEPTH);
		wq_waddr  = WW'((32'(wait_rd_q) + 32'(wait_cnt_q)) % WAIT_DEPTH);
		wq_wdata  = {in_time, in_kind};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			free_map_q   <= '1;
			wait_rd_q    <= '0;
			wait_cnt_q   <= '0;
			cur_slot_q   <= '0;
			total_q      <= '0;
			res_valid_q  <= 1'b0;
			start_mode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// EMIT reloads the output register itself
			if (res_valid_q && m_tready && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_mode_q          <= (in_req == REQ_START);
						res_q.done_server     <= '0;
						res_q.done_kind       <= '0;
						res_q.server_freed    <= 1'b0;
						res_q.dispatched_kind <= '0;
						res_q.error_flag      <= (in_req == REQ_ENQUEUE) &&
						                         !(wait_cnt_q < CW'(WAIT_DEPTH));
						res_q.processed_count <= total_q;
						res_q.last_result     <= 1'b1;
						unique case (in_req)
							REQ_START: begin
								pl_time_q    <= in_time;
								drn_srv_q    <= in_srv;
								disp_kind_q  <= in_kind;
								res_q.result_kind <= RES_START_ACK;
							end
							REQ_ENQUEUE: begin
								res_valid_q <= 1'b1;
								res_q.result_kind <= RES_ENQ_ACK;
								if (wait_cnt_q < CW'(WAIT_DEPTH)) begin
									wait_cnt_q <= wait_cnt_q + 1'b1;
								end
							end
							REQ_SERVICE: begin
								cur_slot_q <= in_slot_m;
								res_q.result_kind <= slot_valid_q[in_slot_m] ?
								                     RES_DONE : RES_EMPTY;
								if (!slot_valid_q[in_slot_m]) begin
									res_valid_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: ;
				ST_POP: begin
					// unlink head and free its entry
					slot_valid_q[cur_now] <= ent_rdata[ENT_W-1];
					slot_heads_q[cur_now] <= ent_rdata[ENT_W-2 -: EW];
					free_map_q[head_e]    <= 1'b1;
					drn_srv_q   <= ent_rdata[5:3];
					drn_kind_q  <= ent_rdata[2:0];
					total_q     <= total_q + 32'd1;
					freed_q     <= (wait_cnt_q == '0);
					disp_kind_q <= (wait_cnt_q != '0) ? wq_rdata[2:0] : 3'd0;
					pl_time_q   <= wq_rdata[10:3];
					if (wait_cnt_q != '0) begin
						wait_rd_q  <= WW'((32'(wait_rd_q) + 32'd1) % WAIT_DEPTH);
						wait_cnt_q <= wait_cnt_q - 1'b1;
					end
				end
				ST_PLACE: begin
					if (free_any) begin
						free_map_q[free_idx]    <= 1'b0;
						slot_valid_q[pl_slot]   <= 1'b1;
						slot_heads_q[pl_slot]   <= free_idx;
					end
					if (start_mode_q) begin
						res_q.error_flag <= !free_any;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						if (!start_mode_q) begin
							res_q.result_kind     <= RES_DONE;
							res_q.done_server     <= drn_srv_q;
							res_q.done_kind       <= drn_kind_q;
							res_q.server_freed    <= freed_q;
							res_q.dispatched_kind <= disp_kind_q;
							res_q.error_flag      <= 1'b0;
							res_q.processed_count <= total_q;
							res_q.last_result     <= !slot_valid_q[cur_now];
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tlast  = res_q.last_result;
	assign m_tdata  = {3'd0, res_q.processed_count, res_q.error_flag,
	                   res_q.dispatched_kind, res_q.server_freed, res_q.done_kind,
	                   res_q.done_server, res_q.result_kind};

`include "timing_wheel_server_dispatcher_core_macros.svh"

	`TW_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !s_tready,
		"ready while busy")
	`TW_ASSERT_NEXT(a_pop_counts, clk, arst_n, state_q == ST_POP,
		total_q == $past(total_q) + 32'd1, "completion count not advanced")
	`TW_ASSERT_IMP(a_wait_bound, clk, arst_n, 1'b1, wait_cnt_q <= CW'(WAIT_DEPTH),
		"wait count overflow")
endmodule
`default_nettype wire

@@ verif/timing_wheel_server_dispatcher_core_tb.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_server_dispatcher_core_tb
// Drives start, enqueue, service and unknown requests into the dispatcher,
// predicts the wheel, entry pool and waiting FIFO, checks every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module timing_wheel_server_dispatcher_core_tb;
	import twsd_pkg::*;

	localparam int NSLOT = 16;
	localparam int NSRV  = 8;
	localparam int WDEP  = 16;
	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;

	timing_wheel_server_dispatcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// wheel shadow
	logic            slot_used [NSLOT];
	logic [2:0]      slot_head [NSLOT];
	logic            ent_more [NSRV];
	logic [2:0]      ent_link [NSRV];
	logic [2:0]      ent_srv [NSRV];
	logic [2:0]      ent_kind [NSRV];
	logic [NSRV-1:0] pool_free;
	logic [7:0]      fifo_time [WDEP];
	logic [2:0]      fifo_kind [WDEP];
	logic [3:0]      fifo_rd;
	int              fifo_cnt;
	logic [3:0]      cur_slot;
	logic [31:0]     done_total;

	result_t pending_results [$];
	int  send_idle_pct, recv_idle_pct;
	int  fail_count = 0;
	int  quiet_cycles = 0;

	function automatic bit take_entry(logic [7:0] t, logic [2:0] srv, logic [2:0] kd);
		logic [3:0] s;
		for (int i = 0; i < NSRV; i++) begin
			if (pool_free[i]) begin
				pool_free[i] = 1'b0;
				s = cur_slot + t[3:0];
				ent_srv[i] = srv;
				ent_kind[i] = kd;
				ent_more[i] = slot_used[s];
				ent_link[i] = slot_head[s];
				slot_head[s] = i[2:0];
				slot_used[s] = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic result_t make_res(logic [1:0] rk, logic [2:0] ds, logic [2:0] dk,
			logic fr, logic [2:0] dp, logic er, logic lst);
		result_t r;
		r.result_kind = rk; r.done_server = ds; r.done_kind = dk; r.server_freed = fr;
		r.dispatched_kind = dp; r.error_flag = er; r.processed_count = done_total;
		r.last_result = lst;
		return r;
	endfunction

	task automatic predict_request(logic [1:0] rq, logic [2:0] srv, logic [7:0] t,
			logic [2:0] kd, logic [3:0] sn);
		logic [2:0] e, esrv, ekind, disp;
		logic       fr;
		bit         ok;
		int         n;
		case (rq)
			REQ_START: begin
				ok = take_entry(t, srv, kd);
				pending_results.push_back(make_res(RES_START_ACK, 3'd0, 3'd0, 1'b0,
					3'd0, !ok, 1'b1));
			end
			REQ_ENQUEUE: begin
				ok = fifo_cnt < WDEP;
				if (ok) begin
					fifo_time[fifo_rd + fifo_cnt[3:0]] = t;
					fifo_kind[fifo_rd + fifo_cnt[3:0]] = kd;
					fifo_cnt++;
				end
				pending_results.push_back(make_res(RES_ENQ_ACK, 3'd0, 3'd0, 1'b0,
					3'd0, !ok, 1'b1));
			end
			REQ_SERVICE: begin
				cur_slot = sn;
				if (!slot_used[sn]) begin
					pending_results.push_back(make_res(RES_EMPTY, 3'd0, 3'd0, 1'b0,
						3'd0, 1'b0, 1'b1));
				end else begin
					n = 0;
					while (slot_used[sn] && n < NSRV + WDEP) begin
						e = slot_head[sn];
						esrv = ent_srv[e];
						ekind = ent_kind[e];
						slot_used[sn] = ent_more[e];
						slot_head[sn] = ent_link[e];
						pool_free[e] = 1'b1;
						done_total++;
						fr = 1'b1;
						disp = 3'd0;
						if (fifo_cnt > 0) begin
							disp = fifo_kind[fifo_rd];
							void'(take_entry(fifo_time[fifo_rd], esrv, disp));
							fifo_rd++;
							fifo_cnt--;
							fr = 1'b0;
						end
						n++;
						pending_results.push_back(make_res(RES_DONE, esrv, ekind, fr, disp,
							1'b0, !slot_used[sn] || n == NSRV + WDEP));
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(logic [1:0] rq, logic [2:0] srv, logic [7:0] t,
			logic [2:0] kd, logic [3:0] sn);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {4'd0, sn, kd, t, srv, rq};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_request(rq, srv, t, kd, sn);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 38)
				send_item(REQ_START, 3'($urandom), 8'($urandom), 3'($urandom_range(6)),
					4'($urandom));
			else if (pick < 60)
				send_item(REQ_ENQUEUE, 3'($urandom), 8'($urandom), 3'($urandom_range(6)),
					4'($urandom));
			else if (pick < 97)
				send_item(REQ_SERVICE, 3'($urandom), 8'($urandom), 3'($urandom),
					4'($urandom));
			else
				send_item(REQ_UNKNOWN, 3'($urandom), 8'($urandom), 3'($urandom),
					4'($urandom));
		end
	endtask

	// extremes of every field, each request type, full pool and full FIFO
	task automatic test_directed();
		send_item(REQ_SERVICE, 3'd0, 8'd0, 3'd0, 4'd0);
		send_item(REQ_START, 3'd7, 8'd255, 3'd6, 4'd15);
		send_item(REQ_START, 3'd0, 8'd0, 3'd0, 4'd0);
		send_item(REQ_UNKNOWN, 3'd7, 8'd255, 3'd7, 4'd15);
		for (int i = 0; i < 7; i++) send_item(REQ_START, i[2:0], 8'd16, i[2:0], 4'd0);
		for (int i = 0; i < 17; i++)
			send_item(REQ_ENQUEUE, 3'd0, i[7:0] * 8'd15, 3'd7, 4'd0);
		send_item(REQ_SERVICE, 3'd7, 8'd255, 3'd7, 4'd0);
		send_item(REQ_SERVICE, 3'd0, 8'd0, 3'd0, 4'd15);
		wait_drained();
	endtask

	task automatic test_random_phase(int sidle, int ridle, int count);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		send_random(count);
		wait_drained();
	endtask

	// results
	always @(posedge clk) begin
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got.result_kind     = m_tdata[1:0];
			got.done_server     = m_tdata[4:2];
			got.done_kind       = m_tdata[7:5];
			got.server_freed    = m_tdata[8];
			got.dispatched_kind = m_tdata[11:9];
			got.error_flag      = m_tdata[12];
			got.processed_count = m_tdata[44:13];
			got.last_result     = m_tlast;
			if (pending_results.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.result_kind !== want.result_kind) begin
					$error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
					fail_count++;
				end
				if (got.done_server !== want.done_server) begin
					$error("done_server exp %0d got %0d", want.done_server, got.done_server);
					fail_count++;
				end
				if (got.done_kind !== want.done_kind) begin
					$error("done_kind exp %0d got %0d", want.done_kind, got.done_kind);
					fail_count++;
				end
				if (got.server_freed !== want.server_freed) begin
					$error("server_freed exp %0d got %0d", want.server_freed,
						got.server_freed);
					fail_count++;
				end
				if (got.dispatched_kind !== want.dispatched_kind) begin
					$error("dispatched_kind exp %0d got %0d", want.dispatched_kind,
						got.dispatched_kind);
					fail_count++;
				end
				if (got.error_flag !== want.error_flag) begin
					$error("error_flag exp %0d got %0d", want.error_flag, got.error_flag);
					fail_count++;
				end
				if (got.processed_count !== want.processed_count) begin
					$error("processed_count exp %0d got %0d", want.processed_count,
						got.processed_count);
					fail_count++;
				end
				if (got.last_result !== want.last_result) begin
					$error("last_result exp %0d got %0d", want.last_result,
						got.last_result);
					fail_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timing_wheel_server_dispatcher_core test failed");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			slot_used[i] = 1'b0; slot_head[i] = 3'd0;
		end
		pool_free = '1;
		fifo_rd = 4'd0; fifo_cnt = 0; cur_slot = 4'd0; done_total = '0;
		send_idle_pct = 21;
		recv_idle_pct = 78;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(21, 78, 150);
		test_random_phase(78, 21, 150);
		test_random_phase(0, 0, 145);
		if (fail_count == 0) begin
			$display("timing_wheel_server_dispatcher_core test passed");
		end else begin
			$display("timing_wheel_server_dispatcher_core test failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
